// ===== hdl/segment_cache_slot_policy_defines.svh =====
// ----------------------------------------------------------------------------
// Segment cache slot policy: assertion macros
// Shared assertion shorthands; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CACHE_SLOT_POLICY_DEFINES_SVH
`define SEGMENT_CACHE_SLOT_POLICY_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SCSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define SCSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/scsp_pkg.sv =====
// ----------------------------------------------------------------------------
// scsp_pkg
// Types, constants and codes shared by the segment cache slot policy block.
// ----------------------------------------------------------------------------
package scsp_pkg;

  // Geometry.
  localparam int SEG_SHIFT    = 20;
  localparam int SEG_BYTES    = 1 << SEG_SHIFT;
  localparam int MAX_SEGMENTS = 4096;
  localparam int MAX_SLOTS    = 256;
  localparam int SEG_W        = 12;
  localparam int SLOT_W       = 8;
  localparam int CNT_W        = 13;
  localparam int SIZE_W       = 33;
  localparam int STAMP_W      = 40;
  localparam int WAIT_W       = 8;

  // Configuration register indexes.
  localparam logic [1:0] REG_TOTAL_SIZE = 2'd0;
  localparam logic [1:0] REG_SLOT_COUNT = 2'd1;

  typedef enum logic [1:0] {
    KIND_STORE, KIND_READ, KIND_RELEASE, KIND_CLEAR
  } kind_t;

  typedef enum logic [2:0] {
    RS_STORED, RS_BUSY, RS_HIT, RS_MISS, RS_EMPTY, RS_BAD_SEG, RS_DONE
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [SEG_W-1:0]    segment;
    logic [31:0]         start_offset;
    logic [SIZE_W-1:0]   read_length;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_index;
    logic                evicted_valid;
    logic [SEG_W-1:0]    evicted_segment;
    logic [SEG_W-1:0]    miss_segment;
    logic                seek_request;
    logic                all_stored;
  } out_item_t;

  // One word of the per-segment table.
  typedef struct packed {
    logic                res;
    logic                once;
    logic [SLOT_W-1:0]   slot;
    logic [WAIT_W-1:0]   waiters;
  } seg_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_ENTRY, ST_FREE, ST_EVICT, ST_VICTIM,
    ST_COMMIT, ST_RSCAN, ST_MISS, ST_STAMP, ST_SERVE, ST_RESP
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_DECODE, OP_ENTRY, OP_FREE, OP_EVICT, OP_VICTIM,
    OP_COMMIT, OP_RSCAN, OP_MISS, OP_STAMP, OP_SERVE, OP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   take_item;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  dec_done;
    logic  ent_res;
    logic  clr_last;
    logic  free_found;
    logic  free_none;
    logic  scan_done;
    logic  scan_miss;
    logic  ev_have;
    logic  out_free;
    logic  cfg_clear;
  } dp_stat_t;

endpackage

// ===== hdl/segment_cache_slot_policy.sv =====
// Throughput: one event in flight; a new beat is taken once the result is registered.
// Reset: a pass clearing every segment entry follows reset, every register write and
//   every clear event; no beat is accepted meanwhile. Results leave via a register.
// ----------------------------------------------------------------------------
// segment_cache_slot_policy
// Tag and replacement engine mapping file segments to RAM slots.
// ----------------------------------------------------------------------------
module segment_cache_slot_policy (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [scsp_pkg::SIZE_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  scsp_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output scsp_pkg::out_item_t         out_data
);

  scsp_pkg::dp_cmd_t  cmd;
  scsp_pkg::dp_stat_t stat;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  // Sequencer.
  scsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  scsp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hdl/scsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// scsp_ctrl
// Sequencer for the slot policy: steps the datapath through each event.
// ----------------------------------------------------------------------------
`include "segment_cache_slot_policy_defines.svh"

module scsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  scsp_pkg::dp_stat_t stat,
  output scsp_pkg::dp_cmd_t  cmd
);

  scsp_pkg::ctrl_state_t state_r, state_nxt;
  logic clr_resp_r, clr_resp_nxt;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= scsp_pkg::ST_CLEAR;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    clr_resp_nxt = clr_resp_r;
    case (state_r)
      scsp_pkg::ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt    = clr_resp_r ? scsp_pkg::ST_RESP : scsp_pkg::ST_IDLE;
          clr_resp_nxt = 1'b0;
        end
      end
      scsp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = scsp_pkg::ST_DECODE;
      end
      scsp_pkg::ST_DECODE: begin
        if (stat.kind == scsp_pkg::KIND_CLEAR) begin
          state_nxt    = scsp_pkg::ST_CLEAR;
          clr_resp_nxt = 1'b1;
        end else if (stat.dec_done) begin
          state_nxt = scsp_pkg::ST_RESP;
        end else if (stat.kind == scsp_pkg::KIND_READ) begin
          state_nxt = scsp_pkg::ST_RSCAN;
        end else begin
          state_nxt = scsp_pkg::ST_ENTRY;
        end
      end
      scsp_pkg::ST_ENTRY: begin
        if (stat.kind != scsp_pkg::KIND_STORE) state_nxt = scsp_pkg::ST_RESP;
        else if (stat.ent_res) state_nxt = scsp_pkg::ST_COMMIT;
        else state_nxt = scsp_pkg::ST_FREE;
      end
      scsp_pkg::ST_FREE: begin
        if (stat.free_found) state_nxt = scsp_pkg::ST_COMMIT;
        else if (stat.free_none) state_nxt = scsp_pkg::ST_EVICT;
      end
      scsp_pkg::ST_EVICT: begin
        if (stat.scan_done)
          state_nxt = stat.ev_have ? scsp_pkg::ST_VICTIM : scsp_pkg::ST_RESP;
      end
      scsp_pkg::ST_VICTIM: state_nxt = scsp_pkg::ST_COMMIT;
      scsp_pkg::ST_COMMIT: state_nxt = scsp_pkg::ST_RESP;
      scsp_pkg::ST_RSCAN: begin
        if (stat.scan_miss) state_nxt = scsp_pkg::ST_MISS;
        else if (stat.scan_done) state_nxt = scsp_pkg::ST_STAMP;
      end
      scsp_pkg::ST_MISS:  state_nxt = scsp_pkg::ST_RESP;
      scsp_pkg::ST_STAMP: begin
        if (stat.scan_done) state_nxt = scsp_pkg::ST_SERVE;
      end
      scsp_pkg::ST_SERVE: state_nxt = scsp_pkg::ST_RESP;
      scsp_pkg::ST_RESP: begin
        if (stat.out_free) state_nxt = scsp_pkg::ST_IDLE;
      end
      default: state_nxt = scsp_pkg::ST_CLEAR;
    endcase
    // A register write restarts the clearing pass from any state.
    if (stat.cfg_clear) begin
      state_nxt    = scsp_pkg::ST_CLEAR;
      clr_resp_nxt = 1'b0;
    end
  end

  // Commands to the datapath.
  always_comb begin
    in_ready      = (state_r == scsp_pkg::ST_IDLE);
    cmd.take_item = in_ready && in_valid;
    case (state_r)
      scsp_pkg::ST_CLEAR:  cmd.op = scsp_pkg::OP_CLEAR;
      scsp_pkg::ST_DECODE: cmd.op = scsp_pkg::OP_DECODE;
      scsp_pkg::ST_ENTRY:  cmd.op = scsp_pkg::OP_ENTRY;
      scsp_pkg::ST_FREE:   cmd.op = scsp_pkg::OP_FREE;
      scsp_pkg::ST_EVICT:  cmd.op = scsp_pkg::OP_EVICT;
      scsp_pkg::ST_VICTIM: cmd.op = scsp_pkg::OP_VICTIM;
      scsp_pkg::ST_COMMIT: cmd.op = scsp_pkg::OP_COMMIT;
      scsp_pkg::ST_RSCAN:  cmd.op = scsp_pkg::OP_RSCAN;
      scsp_pkg::ST_MISS:   cmd.op = scsp_pkg::OP_MISS;
      scsp_pkg::ST_STAMP:  cmd.op = scsp_pkg::OP_STAMP;
      scsp_pkg::ST_SERVE:  cmd.op = scsp_pkg::OP_SERVE;
      scsp_pkg::ST_RESP:   cmd.op = stat.out_free ? scsp_pkg::OP_RESP : scsp_pkg::OP_NONE;
      default:             cmd.op = scsp_pkg::OP_NONE;
    endcase
  end

  // An accepted beat is decoded in the following cycle unless a register write comes with it.
  `SCSP_ASSERT_NEXT(a_take_decode, cmd.take_item && !stat.cfg_clear, state_r == scsp_pkg::ST_DECODE, "accepted beat not decoded")

endmodule

// ===== hdl/scsp_dp.sv =====
// ----------------------------------------------------------------------------
// scsp_dp
// Datapath: segment table, stamp memory, slot map, scan pipeline and result.
// ----------------------------------------------------------------------------
`include "segment_cache_slot_policy_defines.svh"

module scsp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [1:0]                    cfg_index,
  input  logic [scsp_pkg::SIZE_W-1:0]   cfg_data,
  input  scsp_pkg::in_item_t            in_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output scsp_pkg::out_item_t           out_data,
  input  scsp_pkg::dp_cmd_t             cmd,
  output scsp_pkg::dp_stat_t            stat
);

  localparam int SW = scsp_pkg::SIZE_W;
  localparam int CW = scsp_pkg::CNT_W;
  localparam int GW = scsp_pkg::SEG_W;
  localparam int LW = scsp_pkg::SLOT_W;
  localparam int TW = scsp_pkg::STAMP_W;
  localparam int SH = scsp_pkg::SEG_SHIFT;

  // Storage.
  scsp_pkg::seg_entry_t seg_mem [scsp_pkg::MAX_SEGMENTS];
  logic [TW-1:0]        stamp_mem [scsp_pkg::MAX_SLOTS];

  // Registers.
  logic [SW-1:0] total_r, total_nxt;
  logic [8:0]    slots_cfg_r, slots_cfg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [scsp_pkg::MAX_SLOTS-1:0] used_r, used_nxt;
  logic [TW-1:0] stamp_cnt_r, stamp_cnt_nxt;
  logic [SW-1:0] served_r, served_nxt;
  logic [GW-1:0] peak_r, peak_nxt;
  logic [CW-1:0] stored_r, stored_nxt;
  logic          p1_v_r, p1_v_nxt, p2_v_r, p2_v_nxt, have_r, have_nxt;
  logic          out_valid_r, out_valid_nxt;
  scsp_pkg::in_item_t   item_r;
  scsp_pkg::seg_entry_t ent_q_r, seg_ent_r, seg_ent_nxt;
  scsp_pkg::seg_entry_t p2_ent_r, p2_ent_nxt, vict_ent_r, vict_ent_nxt;
  logic [TW-1:0] stamp_q_r, best_r, best_nxt;
  // The first pipeline stage carries one extra bit so a read can reach past the table.
  logic [CW-1:0] p1_seg_r, p1_seg_nxt;
  logic [GW-1:0] p2_seg_r, p2_seg_nxt, victim_r, victim_nxt;
  logic [LW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] end_r, end_nxt;
  scsp_pkg::status_t status_r, status_nxt;
  logic          ev_v_r, ev_v_nxt, seek_r, seek_nxt;
  logic [GW-1:0] ev_seg_r, ev_seg_nxt, miss_r, miss_nxt;
  scsp_pkg::out_item_t out_r, out_nxt;

  // Memory ports.
  logic                 mem_rd_en, mem_wr_en, st_rd_en, st_wr_en;
  logic [GW-1:0]        mem_rd_addr, mem_wr_addr;
  scsp_pkg::seg_entry_t mem_wr_data;
  logic [LW-1:0]        st_rd_addr, st_wr_addr;
  logic [TW-1:0]        st_wr_data;

  // Derived configuration: segment count and slots in use.
  logic [SW:0]   seg_sum;
  logic [SW-SH:0] seg_ceil;
  logic [CW-1:0] nsegs;
  logic [8:0]    ns_cap, ns_low;
  logic [CW:0]   ns_lim;
  logic [8:0]    nslots;

  always_comb begin
    seg_sum  = {1'b0, total_r} + (SW+1)'(scsp_pkg::SEG_BYTES - 1);
    seg_ceil = seg_sum[SW:SH];
    nsegs    = (seg_ceil > (SW-SH+1)'(scsp_pkg::MAX_SEGMENTS)) ?
               CW'(scsp_pkg::MAX_SEGMENTS) : CW'(seg_ceil);
    ns_cap   = (slots_cfg_r > 9'(scsp_pkg::MAX_SLOTS)) ? 9'(scsp_pkg::MAX_SLOTS) : slots_cfg_r;
    ns_low   = (ns_cap < 9'd4) ? 9'd4 : ns_cap;
    ns_lim   = {1'b0, nsegs} + (CW+1)'(4);
    nslots   = ((CW+1)'(ns_low) > ns_lim) ? 9'(ns_lim) : ns_low;
  end

  // Scan helpers.
  logic [GW-1:0] rng_first;
  logic [CW-1:0] rng_last;
  logic [SW-1:0] end_m1;
  logic          read_issue, evict_issue, scan_issue, seg_ok, read_empty;
  logic          rs_miss_now, cand, better, urgent, far_mode, cfg_clear;
  logic [SW:0]   end_sum;
  logic [SW:0]   srv_plus;

  always_comb begin
    rng_first   = item_r.start_offset[31:SH];
    end_m1      = end_r - SW'(1);
    rng_last    = end_m1[SW-1:SH];
    read_issue  = cnt_r <= rng_last;
    evict_issue = cnt_r < nsegs;
    scan_issue  = (cmd.op == scsp_pkg::OP_EVICT) ? evict_issue : read_issue;
    seg_ok      = {1'b0, item_r.segment} < nsegs;
    read_empty  = (item_r.read_length == '0) || ({1'b0, item_r.start_offset} >= total_r);
    end_sum     = {2'b0, item_r.start_offset} + {1'b0, item_r.read_length};
    srv_plus    = {1'b0, served_r} + (SW+1)'(scsp_pkg::SEG_BYTES);
    rs_miss_now = (cmd.op == scsp_pkg::OP_RSCAN) && p1_v_r &&
                  ((p1_seg_r >= nsegs) || !ent_q_r.res);
    urgent      = (seg_ent_r.waiters != '0);
    far_mode    = (peak_r != '0);
    cand        = p1_v_r && ent_q_r.res && (ent_q_r.waiters == '0) &&
                  ((served_r[SW-1:SH] > p1_seg_r) ||
                   (ent_q_r.once && (urgent || far_mode)));
    better      = p2_v_r && (!have_r || (stamp_q_r < best_r));
    cfg_clear   = cfg_valid && ((cfg_index == scsp_pkg::REG_TOTAL_SIZE) ||
                                (cfg_index == scsp_pkg::REG_SLOT_COUNT));
  end

  // Status to the sequencer.
  always_comb begin
    stat.kind       = item_r.kind;
    case (item_r.kind)
      scsp_pkg::KIND_READ:  stat.dec_done = read_empty;
      scsp_pkg::KIND_CLEAR: stat.dec_done = 1'b1;
      default:              stat.dec_done = !seg_ok;
    endcase
    stat.ent_res    = ent_q_r.res;
    stat.clr_last   = (cnt_r == CW'(scsp_pkg::MAX_SEGMENTS - 1));
    stat.free_found = (cnt_r < CW'(nslots)) && !used_r[cnt_r[LW-1:0]];
    stat.free_none  = !(cnt_r < CW'(nslots));
    stat.scan_done  = !scan_issue && !p1_v_r && !p2_v_r;
    stat.scan_miss  = rs_miss_now;
    stat.ev_have    = have_r;
    stat.out_free   = !out_valid_r || out_ready;
    stat.cfg_clear  = cfg_clear;
  end

  // Next-state logic for every operation.
  always_comb begin
    total_nxt     = total_r;
    slots_cfg_nxt = slots_cfg_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    stamp_cnt_nxt = stamp_cnt_r;
    served_nxt    = served_r;
    peak_nxt      = peak_r;
    stored_nxt    = stored_r;
    p1_v_nxt      = p1_v_r;
    p1_seg_nxt    = p1_seg_r;
    p2_v_nxt      = p2_v_r;
    p2_seg_nxt    = p2_seg_r;
    p2_ent_nxt    = p2_ent_r;
    have_nxt      = have_r;
    best_nxt      = best_r;
    victim_nxt    = victim_r;
    vict_ent_nxt  = vict_ent_r;
    seg_ent_nxt   = seg_ent_r;
    slot_nxt      = slot_r;
    end_nxt       = end_r;
    status_nxt    = status_r;
    ev_v_nxt      = ev_v_r;
    ev_seg_nxt    = ev_seg_r;
    miss_nxt      = miss_r;
    seek_nxt      = seek_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = cnt_r[GW-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = item_r.segment;
    mem_wr_data   = '0;
    st_rd_en      = 1'b0;
    st_rd_addr    = ent_q_r.slot;
    st_wr_en      = 1'b0;
    st_wr_addr    = slot_r;
    st_wr_data    = stamp_cnt_r + TW'(1);

    case (cmd.op)
      // Clearing pass: one segment entry per cycle.
      scsp_pkg::OP_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cnt_r[GW-1:0];
        cnt_nxt     = cnt_r + CW'(1);
      end
      // Decode the beat, set the default result and prime the scans.
      scsp_pkg::OP_DECODE: begin
        ev_v_nxt    = 1'b0;
        ev_seg_nxt  = '0;
        miss_nxt    = '0;
        seek_nxt    = 1'b0;
        p1_v_nxt    = 1'b0;
        p2_v_nxt    = 1'b0;
        cnt_nxt     = {1'b0, rng_first};
        end_nxt     = (end_sum > {1'b0, total_r}) ? total_r : end_sum[SW-1:0];
        mem_rd_en   = 1'b1;
        mem_rd_addr = item_r.segment;
        case (item_r.kind)
          scsp_pkg::KIND_READ: status_nxt = scsp_pkg::RS_EMPTY;
          scsp_pkg::KIND_CLEAR: begin
            status_nxt    = scsp_pkg::RS_DONE;
            cnt_nxt       = '0;
            used_nxt      = '0;
            stamp_cnt_nxt = '0;
            served_nxt    = '0;
            peak_nxt      = '0;
            stored_nxt    = '0;
          end
          default: status_nxt = scsp_pkg::RS_BAD_SEG;
        endcase
      end
      // Entry of the addressed segment is in hand.
      scsp_pkg::OP_ENTRY: begin
        seg_ent_nxt = ent_q_r;
        slot_nxt    = ent_q_r.slot;
        cnt_nxt     = '0;
        if (item_r.kind == scsp_pkg::KIND_RELEASE) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = ent_q_r;
          if (ent_q_r.waiters != '0) mem_wr_data.waiters = ent_q_r.waiters - 8'd1;
          status_nxt  = scsp_pkg::RS_DONE;
        end
      end
      // Lowest free slot, one slot per cycle.
      scsp_pkg::OP_FREE: begin
        if (stat.free_found) begin
          slot_nxt = cnt_r[LW-1:0];
        end else if (stat.free_none) begin
          cnt_nxt  = CW'(1);
          p1_v_nxt = 1'b0;
          p2_v_nxt = 1'b0;
          have_nxt = 1'b0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      // Victim search: entry read, stamp read, compare.
      scsp_pkg::OP_EVICT: begin
        mem_rd_en  = evict_issue;
        p1_v_nxt   = evict_issue;
        p1_seg_nxt = cnt_r;
        if (evict_issue) cnt_nxt = cnt_r + CW'(1);
        st_rd_en   = cand;
        p2_v_nxt   = cand;
        p2_seg_nxt = p1_seg_r[GW-1:0];
        p2_ent_nxt = ent_q_r;
        if (better) begin
          have_nxt     = 1'b1;
          best_nxt     = stamp_q_r;
          victim_nxt   = p2_seg_r;
          vict_ent_nxt = p2_ent_r;
        end
        if (stat.scan_done && !have_r) status_nxt = scsp_pkg::RS_BUSY;
      end
      // Release the victim's slot.
      scsp_pkg::OP_VICTIM: begin
        mem_wr_en       = 1'b1;
        mem_wr_addr     = victim_r;
        mem_wr_data     = vict_ent_r;
        mem_wr_data.res = 1'b0;
        slot_nxt        = vict_ent_r.slot;
        ev_v_nxt        = 1'b1;
        ev_seg_nxt      = victim_r;
      end
      // Place the segment in its slot and stamp it.
      scsp_pkg::OP_COMMIT: begin
        mem_wr_en           = 1'b1;
        mem_wr_data.res     = 1'b1;
        mem_wr_data.once    = 1'b1;
        mem_wr_data.slot    = slot_r;
        mem_wr_data.waiters = seg_ent_r.waiters;
        used_nxt[slot_r]    = 1'b1;
        st_wr_en            = 1'b1;
        stamp_cnt_nxt       = stamp_cnt_r + TW'(1);
        if (!seg_ent_r.once) stored_nxt = stored_r + CW'(1);
        status_nxt          = scsp_pkg::RS_STORED;
      end
      // Presence check over the read range.
      scsp_pkg::OP_RSCAN: begin
        if (!rs_miss_now) begin
          mem_rd_en  = read_issue;
          p1_v_nxt   = read_issue;
          p1_seg_nxt = cnt_r;
          if (read_issue) cnt_nxt = cnt_r + CW'(1);
        end
        if (stat.scan_done) cnt_nxt = {1'b0, rng_first};
      end
      // First missing segment: raise peak and add a waiter.
      scsp_pkg::OP_MISS: begin
        status_nxt = scsp_pkg::RS_MISS;
        miss_nxt   = p1_seg_r[GW-1:0];
        if (p1_seg_r < nsegs) begin
          seek_nxt    = (p1_seg_r != '0);
          if (p1_seg_r[GW-1:0] > peak_r) peak_nxt = p1_seg_r[GW-1:0];
          mem_wr_en   = 1'b1;
          mem_wr_addr = p1_seg_r[GW-1:0];
          mem_wr_data = ent_q_r;
          if (ent_q_r.waiters != 8'hFF) mem_wr_data.waiters = ent_q_r.waiters + 8'd1;
        end
      end
      // Stamp every slot of a hit range in segment order.
      scsp_pkg::OP_STAMP: begin
        mem_rd_en  = read_issue;
        p1_v_nxt   = read_issue;
        p1_seg_nxt = cnt_r;
        if (read_issue) cnt_nxt = cnt_r + CW'(1);
        if (p1_v_r) begin
          st_wr_en      = 1'b1;
          st_wr_addr    = ent_q_r.slot;
          stamp_cnt_nxt = stamp_cnt_r + TW'(1);
        end
      end
      // Advance the served mark.
      scsp_pkg::OP_SERVE: begin
        status_nxt = scsp_pkg::RS_HIT;
        if (({2'b0, item_r.start_offset} <= srv_plus) && (end_r > served_r))
          served_nxt = end_r;
      end
      // Load the output register.
      scsp_pkg::OP_RESP: begin
        out_valid_nxt           = 1'b1;
        out_nxt.status          = status_r;
        out_nxt.slot_index      = (status_r == scsp_pkg::RS_STORED) ? slot_r : '0;
        out_nxt.evicted_valid   = ev_v_r;
        out_nxt.evicted_segment = ev_seg_r;
        out_nxt.miss_segment    = miss_r;
        out_nxt.seek_request    = seek_r;
        out_nxt.all_stored      = (stored_r >= nsegs);
      end
      default: begin
      end
    endcase

    // A register write clears the session and restarts the clearing pass.
    if (cfg_clear) begin
      if (cfg_index == scsp_pkg::REG_TOTAL_SIZE) total_nxt = cfg_data;
      else slots_cfg_nxt = cfg_data[8:0];
      cnt_nxt       = '0;
      used_nxt      = '0;
      stamp_cnt_nxt = '0;
      served_nxt    = '0;
      peak_nxt      = '0;
      stored_nxt    = '0;
      p1_v_nxt      = 1'b0;
      p2_v_nxt      = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= SW'(1);
      slots_cfg_r <= 9'd64;
      cnt_r       <= '0;
      used_r      <= '0;
      stamp_cnt_r <= '0;
      served_r    <= '0;
      peak_r      <= '0;
      stored_r    <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      slots_cfg_r <= slots_cfg_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      stamp_cnt_r <= stamp_cnt_nxt;
      served_r    <= served_nxt;
      peak_r      <= peak_nxt;
      stored_r    <= stored_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take_item) item_r <= in_data;
    p1_seg_r   <= p1_seg_nxt;
    p2_seg_r   <= p2_seg_nxt;
    p2_ent_r   <= p2_ent_nxt;
    best_r     <= best_nxt;
    victim_r   <= victim_nxt;
    vict_ent_r <= vict_ent_nxt;
    seg_ent_r  <= seg_ent_nxt;
    slot_r     <= slot_nxt;
    end_r      <= end_nxt;
    status_r   <= status_nxt;
    ev_v_r     <= ev_v_nxt;
    ev_seg_r   <= ev_seg_nxt;
    miss_r     <= miss_nxt;
    seek_r     <= seek_nxt;
    out_r      <= out_nxt;
  end

  // Segment table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_wr_en) seg_mem[mem_wr_addr] <= mem_wr_data;
    if (mem_rd_en) ent_q_r <= seg_mem[mem_rd_addr];
  end

  // Use stamps: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (st_wr_en) stamp_mem[st_wr_addr] <= st_wr_data;
    if (st_rd_en) stamp_q_r <= stamp_mem[st_rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A committed slot is marked in use.
  `SCSP_ASSERT_NEXT(a_commit_used, cmd.op == scsp_pkg::OP_COMMIT && !cfg_clear, used_r[$past(slot_r)], "committed slot not marked used")
  // Only a store can report an eviction.
  `SCSP_ASSERT_ALWAYS(a_evict_store, !out_valid_r || !out_r.evicted_valid || out_r.status == scsp_pkg::RS_STORED, "eviction on a non-store result")
  // The stored count never passes the segment table depth.
  `SCSP_ASSERT_ALWAYS(a_stored_cap, stored_r <= CW'(scsp_pkg::MAX_SEGMENTS), "stored count overflow")

endmodule
